>>> src/frame_silence_detector_defines.svh
// ----------------------------------------------------------------------------
// Frame silence detector assertion macros
// Concurrent assertion wrappers; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef FRAME_SILENCE_DETECTOR_DEFINES_SVH
`define FRAME_SILENCE_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FSD_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSD_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> src/fsd_pkg.sv
// ----------------------------------------------------------------------------
// Frame silence detector package
// Widths, payload structs, register and mode codes, mu-law mapping.
// ----------------------------------------------------------------------------
package fsd_pkg;

	localparam int MAX_FRAME_SAMPLES = 1024;
	localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int SUM_W = 16 + $clog2(MAX_FRAME_SAMPLES);
	localparam int QUO_W = 16;
	localparam int REM_W = CNT_W + 1;
	localparam int STEP_W = $clog2(QUO_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;
	localparam int FRM_W = 13;
	localparam int PCT_W = 21;

	localparam logic [CFG_IDX_W-1:0] REG_DETECT_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SIGNAL_FRAMES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SILENCE_FRAMES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECALC_FRAMES = 3'd5;

	localparam logic [1:0] MODE_DISABLED = 2'd0;
	localparam logic [1:0] MODE_FIXED = 2'd1;
	localparam logic [1:0] MODE_ADAPTIVE = 2'd2;

	localparam logic [7:0] START_THRESHOLD_RST = 8'd4;
	localparam logic [14:0] LEVEL_MAX = 15'h7fff;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_in_frame;
	} fsd_in_t;

	typedef struct packed {
		logic        is_silence;
		logic [14:0] frame_level;
		logic [6:0]  ulaw_level;
		logic [7:0]  threshold_now;
	} fsd_out_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} fsd_frame_t;

	typedef struct packed {
		logic [1:0]  detect_mode;
		logic [7:0]  max_threshold;
		logic [11:0] min_signal_frames;
		logic [11:0] min_silence_frames;
		logic [11:0] recalc_frames;
	} fsd_cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_LEVEL,
		BK_APPLY,
		BK_WINDOW
	} back_state_t;

	function automatic logic [6:0] fsd_ulaw(input logic [14:0] lin);
		logic [15:0] v;
		logic [3:0]  seg;
		v = {1'b0, lin} + 16'h0084;
		seg = 4'd8;
		for (int s = 7; s >= 0; s--) begin
			if (v < (16'd1 << (8 + s))) begin
				seg = 4'(s);
			end
		end
		if (seg == 4'd8) begin
			return 7'h7f;
		end
		return {seg[2:0], 4'(v >> (seg + 4'd3))};
	endfunction

endpackage

>>> src/fsd_front.sv
// ----------------------------------------------------------------------------
// Frame silence detector front end
// Accumulates absolute sample values and pushes each closed frame.
// ----------------------------------------------------------------------------
module fsd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fsd_pkg::fsd_in_t   in_data,
	output logic               push_valid,
	input  logic               push_ready,
	output fsd_pkg::fsd_frame_t push_data
);
	import fsd_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      mag;
	logic             room;
	logic [SUM_W-1:0] sum_nx;
	logic [CNT_W-1:0] cnt_nx;
	logic             accept;

	assign mag = in_data.sample[15] ? (~in_data.sample + 16'd1) : in_data.sample;
	assign room = cnt_q < CNT_W'(MAX_FRAME_SAMPLES);
	assign sum_nx = room ? (sum_q + SUM_W'(mag)) : sum_q;
	assign cnt_nx = room ? (cnt_q + CNT_W'(1)) : cnt_q;

	assign in_ready = push_ready || !in_data.last_in_frame;
	assign accept = in_valid && in_ready;
	assign push_valid = in_valid && in_data.last_in_frame;
	assign push_data.sum = sum_nx;
	assign push_data.count = cnt_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (in_data.last_in_frame) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

endmodule

>>> src/fsd_queue.sv
// ----------------------------------------------------------------------------
// Frame silence detector frame queue
// Short queue of closed frames between the front end and the back end.
// ----------------------------------------------------------------------------
`include "frame_silence_detector_defines.svh"

module fsd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  fsd_pkg::fsd_frame_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output fsd_pkg::fsd_frame_t pop_data
);
	import fsd_pkg::*;

	fsd_frame_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`FSD_NEVER(a_q_overfill, clk, arst_n, count_q > QCNT_W'(QUEUE_DEPTH), "queue overfilled")
	`FSD_NEVER(a_q_pop_empty, clk, arst_n, pop_ready && count_q == '0 && pop, "pop from empty")

endmodule

>>> src/fsd_back.sv
// ----------------------------------------------------------------------------
// Frame silence detector back end
// Divides the frame sum, maps to mu-law, runs hangover and threshold logic.
// ----------------------------------------------------------------------------
`include "frame_silence_detector_defines.svh"

module fsd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  fsd_pkg::fsd_cfg_t   cfg,
	input  logic                thr_load,
	input  logic [7:0]          thr_value,
	input  logic                frame_valid,
	output logic                frame_ready,
	input  fsd_pkg::fsd_frame_t frame,
	output logic                out_valid,
	input  logic                out_ready,
	output fsd_pkg::fsd_out_t   out_data
);
	import fsd_pkg::*;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic [14:0]       level_q;
	logic [6:0]        ulaw_q;
	logic              talking_q;
	logic [FRM_W-1:0]  tc_q;
	logic [FRM_W-1:0]  sig_q;
	logic [FRM_W-1:0]  sil_q;
	logic [7:0]        thr_q;
	logic [7:0]        weak_q;
	logic [7:0]        loud_q;
	fsd_out_t          out_q;
	logic              out_valid_q;
	logic              out_load;

	logic [REM_W-1:0]  shifted;
	logic              ge;
	logic [14:0]       mean;

	logic              enabled;
	logic              have_sig;
	logic [11:0]       limit;
	logic [FRM_W-1:0]  tc_inc;
	logic              differ;
	logic              flip;
	logic [7:0]        lvl8;
	logic [7:0]        weak_b;
	logic [7:0]        loud_b;
	logic [FRM_W-1:0]  sig_b;
	logic [FRM_W-1:0]  sil_b;

	logic [FRM_W:0]    total;
	logic              win_end;
	logic [PCT_W-1:0]  s100;
	logic [PCT_W-1:0]  t96;
	logic [PCT_W-1:0]  t81;
	logic [PCT_W-1:0]  t10;
	logic [PCT_W-1:0]  t5;
	logic [8:0]        cur9;
	logic [8:0]        w1;
	logic [8:0]        nt;
	logic [7:0]        thr_new;
	logic              thr_upd;

	assign shifted = {rem_q[REM_W-2:0], quo_q[QUO_W-1]};
	assign ge = shifted >= REM_W'(dvs_q);
	assign mean = (quo_q > QUO_W'(LEVEL_MAX)) ? LEVEL_MAX : quo_q[14:0];

	assign enabled = (cfg.detect_mode == MODE_FIXED) || (cfg.detect_mode == MODE_ADAPTIVE);
	assign lvl8 = {1'b0, ulaw_q};
	assign have_sig = lvl8 > thr_q;
	assign limit = talking_q ? cfg.min_silence_frames : cfg.min_signal_frames;
	assign tc_inc = tc_q + FRM_W'(1);
	assign differ = talking_q != have_sig;
	assign flip = differ && (tc_inc > FRM_W'(limit));
	assign weak_b = flip ? 8'hff : weak_q;
	assign loud_b = flip ? 8'h00 : loud_q;
	assign sig_b = flip ? '0 : sig_q;
	assign sil_b = flip ? '0 : sil_q;

	assign total = {1'b0, sig_q} + {1'b0, sil_q};
	assign win_end = total > (FRM_W + 1)'(cfg.recalc_frames);
	assign s100 = PCT_W'(sig_q) * PCT_W'(100);
	assign t96 = PCT_W'(total) * PCT_W'(96);
	assign t81 = PCT_W'(total) * PCT_W'(81);
	assign t10 = PCT_W'(total) * PCT_W'(10);
	assign t5 = PCT_W'(total) * PCT_W'(5);
	assign cur9 = {1'b0, thr_q};
	assign w1 = {1'b0, weak_q} + 9'd1;

	always_comb begin
		nt = cur9;
		if (s100 >= t96) begin
			if (w1 >= cur9) begin
				nt = cur9 + ((w1 - cur9) >> 1);
			end
		end else if (s100 < t5) begin
			nt = ((cur9 + {1'b0, loud_q}) >> 1) + 9'd1;
		end else if (s100 >= t81) begin
			nt = cur9 + 9'd1;
		end else if (s100 < t10) begin
			nt = (thr_q != 8'd0) ? (cur9 - 9'd1) : 9'd0;
		end
	end

	assign thr_new = (nt > {1'b0, cfg.max_threshold}) ? cfg.max_threshold : nt[7:0];
	assign thr_upd = enabled && win_end && (cfg.detect_mode == MODE_ADAPTIVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		frame_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				frame_ready = 1'b1;
				if (frame_valid) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == STEP_LAST) begin
					state_d = BK_LEVEL;
				end
			end
			BK_LEVEL: begin
				state_d = BK_APPLY;
			end
			BK_APPLY: begin
				state_d = BK_WINDOW;
			end
			BK_WINDOW: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE) begin
			rem_q <= REM_W'(frame.sum >> QUO_W);
			quo_q <= frame.sum[QUO_W-1:0];
			dvs_q <= frame.count;
			step_q <= '0;
		end else if (state_q == BK_DIV) begin
			rem_q <= ge ? (shifted - REM_W'(dvs_q)) : shifted;
			quo_q <= {quo_q[QUO_W-2:0], ge};
			step_q <= step_q + STEP_W'(1);
		end
		if (state_q == BK_LEVEL) begin
			level_q <= mean;
			ulaw_q <= fsd_ulaw(mean);
		end
		if (out_load) begin
			out_q.is_silence <= enabled && !talking_q;
			out_q.frame_level <= level_q;
			out_q.ulaw_level <= ulaw_q;
			out_q.threshold_now <= thr_upd ? thr_new : thr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			talking_q <= 1'b0;
			tc_q <= '0;
			sig_q <= '0;
			sil_q <= '0;
			thr_q <= START_THRESHOLD_RST;
			weak_q <= 8'hff;
			loud_q <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			if (thr_load) begin
				thr_q <= thr_value;
			end else if (out_load && thr_upd) begin
				thr_q <= thr_new;
			end
			if (state_q == BK_APPLY && enabled) begin
				talking_q <= talking_q ^ flip;
				tc_q <= (differ && !flip) ? tc_inc : '0;
				if (have_sig) begin
					weak_q <= (lvl8 < weak_b) ? lvl8 : weak_b;
					loud_q <= loud_b;
					sig_q <= sig_b + FRM_W'(1);
					sil_q <= sil_b;
				end else begin
					weak_q <= weak_b;
					loud_q <= (lvl8 > loud_b) ? lvl8 : loud_b;
					sig_q <= sig_b;
					sil_q <= sil_b + FRM_W'(1);
				end
			end
			if (out_load && enabled && win_end) begin
				weak_q <= 8'hff;
				loud_q <= 8'h00;
				sig_q <= '0;
				sil_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`FSD_ASSERT(a_quot_range, clk, arst_n, (state_q == BK_LEVEL) |-> (quo_q <= 16'h8000), "mean exceeds full scale")
	`FSD_NEVER(a_out_overwrite, clk, arst_n, out_load && out_valid_q && !out_ready, "result overwritten")
	`FSD_ASSERT(a_talk_start, clk, arst_n, $rose(talking_q) |-> (sig_q == 13'd1 && sil_q == 13'd0), "window not restarted on talk start")
	`FSD_ASSERT(a_talk_end, clk, arst_n, $fell(talking_q) |-> (sil_q == 13'd1 && sig_q == 13'd0), "window not restarted on talk end")

endmodule

>>> src/frame_silence_detector.sv
// Path: a closed frame passes the queue, then DIV, LEVEL, APPLY and WINDOW to out_valid.
// Throughput: one sample per cycle while in_ready is high; the back end takes a frame
//   only after its 16-step restoring divider; short frames stall input via the 2-entry queue.
// Reset: arst_n clears accumulators, queue, talk state and window counters; the working
//   threshold loads 4 and the registers take their defaults (adaptive, max 255, 1/25/100).
// ----------------------------------------------------------------------------
// Frame silence detector top level
// Configuration registers, front accumulator, frame queue and back end.
// ----------------------------------------------------------------------------
module frame_silence_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [fsd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fsd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  fsd_pkg::fsd_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output fsd_pkg::fsd_out_t                   out_data
);
	import fsd_pkg::*;

	fsd_cfg_t   cfg_q;
	logic       thr_load;
	logic       push_valid;
	logic       push_ready;
	fsd_frame_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	fsd_frame_t pop_data;

	assign thr_load = cfg_wr_en && (cfg_index == REG_START_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detect_mode <= MODE_ADAPTIVE;
			cfg_q.max_threshold <= 8'd255;
			cfg_q.min_signal_frames <= 12'd1;
			cfg_q.min_silence_frames <= 12'd25;
			cfg_q.recalc_frames <= 12'd100;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DETECT_MODE: cfg_q.detect_mode <= cfg_data[1:0];
				REG_MAX_THRESHOLD: cfg_q.max_threshold <= cfg_data[7:0];
				REG_MIN_SIGNAL_FRAMES: cfg_q.min_signal_frames <= cfg_data;
				REG_MIN_SILENCE_FRAMES: cfg_q.min_silence_frames <= cfg_data;
				REG_RECALC_FRAMES: cfg_q.recalc_frames <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	fsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	fsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.thr_load    (thr_load),
		.thr_value   (cfg_data[7:0]),
		.frame_valid (pop_valid),
		.frame_ready (pop_ready),
		.frame       (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule
